// ----- src/signed_int_to_decimal_ascii_unit_macros.svh -----
// Assertion macros shared by the conversion unit.
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_UNIT_MACROS_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SITDA_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// The consequent must hold in the cycle after the antecedent.
`define SITDA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

// ----- src/sitda_pkg.sv -----
package sitda_pkg;

  localparam int unsigned VALUE_W   = 32;
  localparam int unsigned CHAR_W    = 6;
  localparam int unsigned DIGIT_W   = 4;
  localparam int unsigned MAX_DIGITS = 10;
  localparam int unsigned PTR_W     = 4;

  localparam logic [CHAR_W-1:0]  ASCII_ZERO  = 6'd48;
  localparam logic [CHAR_W-1:0]  ASCII_MINUS = 6'd45;
  localparam logic [VALUE_W-1:0] RECIP_TEN   = 32'hCCCC_CCCD;
  localparam logic [PTR_W-1:0]   LAST_SLOT   = 4'(MAX_DIGITS - 1);

  typedef struct packed {
    logic load;
    logic step;
    logic pop;
    logic sel_sign;
  } sitda_cmd_t;

  typedef struct packed {
    logic conv_done;
    logic negative;
    logic rd_zero;
  } sitda_status_t;

endpackage

// ----- src/sitda_dp.sv -----
module sitda_dp
  import sitda_pkg::*;
(
  input  logic                clk,
  input  logic [VALUE_W-1:0]  value,
  input  sitda_cmd_t          cmd,
  output sitda_status_t       status,
  output logic [CHAR_W-1:0]   character,
  output logic                last_char
);

  logic [VALUE_W-1:0]   mag_r;
  logic                 neg_r;
  logic [DIGIT_W-1:0]   digit_r [MAX_DIGITS];
  logic [PTR_W-1:0]     wr_ptr_r;
  logic [PTR_W-1:0]     rd_ptr_r;

  logic [2*VALUE_W-1:0] prod;
  logic [VALUE_W-1:0]   quot;
  logic [VALUE_W-1:0]   quot_x10;
  logic [VALUE_W-1:0]   rem_full;

  // Division by ten through the reciprocal; the quotient is exact over 32 bits.
  assign prod     = {{VALUE_W{1'b0}}, mag_r} * {{VALUE_W{1'b0}}, RECIP_TEN};
  assign quot     = {3'b000, prod[2*VALUE_W-1:35]};
  assign quot_x10 = {quot[VALUE_W-4:0], 3'b000} + {quot[VALUE_W-2:0], 1'b0};
  assign rem_full = mag_r - quot_x10;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      neg_r    <= value[VALUE_W-1];
      mag_r    <= value[VALUE_W-1] ? (~value + 32'd1) : value;
      wr_ptr_r <= '0;
    end else if (cmd.step) begin
      digit_r[wr_ptr_r] <= rem_full[DIGIT_W-1:0];
      mag_r             <= quot;
      rd_ptr_r          <= wr_ptr_r;
      wr_ptr_r          <= wr_ptr_r + 4'd1;
    end else if (cmd.pop) begin
      rd_ptr_r <= rd_ptr_r - 4'd1;
    end
  end

  assign status.conv_done = (quot == '0) || (wr_ptr_r == LAST_SLOT);
  assign status.negative  = neg_r;
  assign status.rd_zero   = (rd_ptr_r == '0);

  assign character = cmd.sel_sign ? ASCII_MINUS
                                  : (ASCII_ZERO + {2'b00, digit_r[rd_ptr_r]});
  assign last_char = !cmd.sel_sign && (rd_ptr_r == '0);

endmodule

// ----- src/sitda_ctrl.sv -----
`include "signed_int_to_decimal_ascii_unit_macros.svh"

module sitda_ctrl
  import sitda_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  output logic          out_tvalid,
  input  logic          out_tready,
  input  sitda_status_t status,
  output sitda_cmd_t    cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CONV = 2'd1;
  localparam logic [1:0] S_SIGN = 2'd2;
  localparam logic [1:0] S_EMIT = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;
  logic       in_xfer;
  logic       out_xfer;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = (state_r == S_SIGN) || (state_r == S_EMIT);
  assign in_xfer    = in_tvalid && in_tready;
  assign out_xfer   = out_tvalid && out_tready;

  assign cmd.load     = in_xfer;
  assign cmd.step     = (state_r == S_CONV);
  assign cmd.pop      = out_xfer && (state_r == S_EMIT);
  assign cmd.sel_sign = (state_r == S_SIGN);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_xfer) state_nxt = S_CONV;
      end
      S_CONV: begin
        if (status.conv_done) state_nxt = status.negative ? S_SIGN : S_EMIT;
      end
      S_SIGN: begin
        if (out_xfer) state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (out_xfer && status.rd_zero) state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  `SITDA_ASSERT_NEXT(a_load_starts_conv, clk, rst_n, in_xfer, state_r == S_CONV)
  `SITDA_ASSERT_NEXT(a_neg_gets_sign, clk, rst_n,
    (state_r == S_CONV) && status.conv_done && status.negative, state_r == S_SIGN)
  `SITDA_ASSERT_NEXT(a_last_digit_ends, clk, rst_n,
    (state_r == S_EMIT) && out_xfer && status.rd_zero, in_tready)
  `SITDA_ASSERT_IMPLY(a_no_overlap, clk, rst_n, out_tvalid, !in_tready)

endmodule

// ----- src/signed_int_to_decimal_ascii_unit.sv -----
// Signed 32-bit integer to decimal ASCII text converter.
// The input channel (in_*) takes one two's complement value per transaction.
// The output channel (out_*) sends its decimal text one character per
// transaction, most significant digit first, with a leading '-' for negative
// values and no leading zeros; out_tlast marks the final character.
// A conversion of a value with n decimal digits runs an accept step, n
// divide-by-ten steps in the datapath (one reciprocal multiply each), and
// then the output of its n or n + 1 characters, one character per cycle
// while the receiver does not stall.
// One value is handled at a time; in_tready is low from accept until the
// last character has been taken.
// A stalled receiver simply holds the current character and out_tlast
// stable until out_tready rises; nothing is lost or repeated.
// Reset returns the controller to idle, drops out_tvalid and raises in_tready.
module signed_int_to_decimal_ascii_unit
  import sitda_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] value
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [5:0] character, [7:6] zero
  output logic        out_tlast   // last_char
);

  sitda_cmd_t          cmd;
  sitda_status_t       status;
  logic [CHAR_W-1:0]   character;

  sitda_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .status     (status),
    .cmd        (cmd)
  );

  sitda_dp u_dp (
    .clk       (clk),
    .value     (in_tdata),
    .cmd       (cmd),
    .status    (status),
    .character (character),
    .last_char (out_tlast)
  );

  assign out_tdata = {2'b00, character};

endmodule

// ----- tb/sv/decimal_text_checker.sv -----
module decimal_text_checker
  import sitda_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [31:0] in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [7:0]  out_tdata,
  input  logic        out_tlast,
  output int          mismatch_count,
  output int          chars_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [VALUE_W-1:0] RADIX = 10;
  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic [CHAR_W-1:0] code;
    logic              is_last;
  } text_char_t;

  text_char_t awaited_text[$];
  int         error_total;

  function automatic void queue_decimal_text(input logic [VALUE_W-1:0] value);
    logic [VALUE_W-1:0] magnitude;
    logic [DIGIT_W-1:0] digit_buf[MAX_DIGITS];
    int                 n_digits;
    text_char_t         ch;
    magnitude = value[VALUE_W-1] ? (~value + 1'b1) : value;
    n_digits  = 0;
    do begin
      digit_buf[n_digits] = DIGIT_W'(magnitude % RADIX);
      magnitude           = magnitude / RADIX;
      n_digits++;
    end while (magnitude != 0);
    if (value[VALUE_W-1]) begin
      ch.code    = ASCII_MINUS;
      ch.is_last = 1'b0;
      awaited_text.push_back(ch);
    end
    for (int i = n_digits - 1; i >= 0; i--) begin
      ch.code    = ASCII_ZERO + CHAR_W'(digit_buf[i]);
      ch.is_last = (i == 0);
      awaited_text.push_back(ch);
    end
  endfunction

  always @(posedge clk) begin
    text_char_t want;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        queue_decimal_text(in_tdata);
      end
      if (out_tvalid && out_tready) begin
        if (awaited_text.size() == 0) begin
          error_total++;
          if (error_total <= REPORT_LIMIT) begin
            $display("%0t: unexpected character 0x%02h (last %0b), no conversion pending",
                     $realtime, out_tdata, out_tlast);
          end
        end else begin
          want = awaited_text.pop_front();
          if (out_tdata != {{(8 - CHAR_W){1'b0}}, want.code} || out_tlast != want.is_last) begin
            error_total++;
            if (error_total <= REPORT_LIMIT) begin
              $display("%0t: character mismatch, expected 0x%02h last %0b, got 0x%02h last %0b",
                       $realtime, want.code, want.is_last, out_tdata, out_tlast);
            end
          end
        end
      end
    end
    mismatch_count <= error_total;
    chars_pending  <= awaited_text.size();
  end

endmodule

// ----- tb/sv/testbench.sv -----
module testbench;
  import sitda_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_PCT     = 28;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int HOLD_CYCLES  = 300;
  localparam int TAIL_CYCLES  = 40;
  localparam int RANDOM_ITEMS = 380;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [7:0]  out_tdata;
  logic        out_tlast;

  int          mismatch_count;
  int          chars_pending;
  int          cycle_count;
  int          hold_left;
  bit          hold_arm;
  bit          hold_done;
  bit          steady;

  signed_int_to_decimal_ascii_unit uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  decimal_text_checker checker_inst (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .out_tlast      (out_tlast),
    .mismatch_count (mismatch_count),
    .chars_pending  (chars_pending)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    out_tready = 1'b0;
    hold_left  = 0;
    hold_done  = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (hold_arm && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  task automatic send_value(input logic [31:0] value);
    @(negedge clk);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= value;
    do @(posedge clk); while (!in_tready);
  endtask

  function automatic logic [31:0] pick_value();
    int unsigned n_digits;
    int unsigned lo;
    int unsigned hi;
    logic [31:0] v;
    case ($urandom_range(9))
      0, 1: v = $urandom();
      2: begin
        lo = 1;
        repeat ($urandom_range(9)) lo = lo * 10;
        v  = $urandom_range(1) ? lo : lo - 1;
      end
      3: v = $urandom_range(1) ? 32'h8000_0000 + $urandom_range(3) : 32'h7FFF_FFFF - $urandom_range(3);
      default: begin
        n_digits = $urandom_range(10, 1);
        lo = 1;
        repeat (n_digits - 1) lo = lo * 10;
        hi = (n_digits == 10) ? 32'h7FFF_FFFF : lo * 10 - 1;
        v  = (n_digits == 1) ? $urandom_range(9) : $urandom_range(hi, lo);
      end
    endcase
    if ($urandom_range(1)) v = ~v + 1'b1;
    return v;
  endfunction

  initial begin
    logic [31:0] directed[$];
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    steady    = 1'b0;
    hold_arm  = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    directed = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'd9, 32'd10, -32'sd10, 32'd99, 32'd100,
                 -32'sd100, 32'd12345, -32'sd54321, 32'd999999999, -32'sd999999999,
                 32'd1000000000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001,
                 32'h5555_5555, 32'hAAAA_AAAA, 32'd123456789, -32'sd7};
    foreach (directed[i]) send_value(directed[i]);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      steady = (i >= 60 && i < 150);
      if (i == 200) hold_arm = 1'b1;
      send_value(pick_value());
    end
    @(negedge clk);
    in_tvalid <= 1'b0;

    do @(negedge clk); while (chars_pending != 0);
    repeat (TAIL_CYCLES) @(negedge clk);
    if (mismatch_count == 0 && chars_pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ----- signed_int_to_decimal_ascii_unit.f -----
+incdir+src
src/sitda_pkg.sv
src/sitda_dp.sv
src/sitda_ctrl.sv
src/signed_int_to_decimal_ascii_unit.sv
tb/sv/decimal_text_checker.sv
tb/sv/testbench.sv
